// ----- design/depth_median3x3_decimate2_assert.svh -----
// Assertion macros used by the filter RTL.
`ifndef DEPTH_MEDIAN3X3_DECIMATE2_ASSERT_SVH
`define DEPTH_MEDIAN3X3_DECIMATE2_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`ifndef NO_ASSERTIONS
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/dmd_pkg.sv -----
`timescale 1ns / 1ps

package dmd_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int PIXEL_BITS     = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int COORD_BITS     = 9;
   localparam int SIZE_BITS      = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [COL_BITS:0]     wlim_type;
   typedef logic [ROW_BITS:0]     hlim_type;
   typedef logic [SIZE_BITS-1:0]  size_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // one window column, sorted
   typedef struct packed {
      pixel_type lo;
      pixel_type md;
      pixel_type hi;
   } column_type;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pixel_type max3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic column_type sort3(input pixel_type a, input pixel_type b,
                                        input pixel_type c);
      column_type s;
      s.lo = min3(a, b, c);
      s.md = med3(a, b, c);
      s.hi = max3(a, b, c);
      return s;
   endfunction

endpackage

// ----- design/dmd_ram.sv -----
`timescale 1ns / 1ps

module dmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read during write to the same address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/depth_median3x3_decimate2.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Word
// req      in   req_valid/ready    req_depth_sample, req_frame_start
// rsp      out  rsp_valid/ready    rsp_filtered_depth, rsp_out_column, rsp_out_row,
//                                  rsp_frame_last
// csr      in   csr_write_enable   csr_index, csr_write_data
//
// One pixel is taken per cycle unless a held result stalls the input. A reduced pixel
// passes line store read, window shift, median and output register after the pixel that completes it.
// The two line stores are single write, single read memories; a pixel reads and
// rewrites its column, with a bypass when the next pixel hits the same column.
// Reset is synchronous and clears counters, window and valid bits; the stores
// need no clearing. A stalled result holds the window and at most one pixel behind it.

module depth_median3x3_decimate2 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dmd_pkg::SAMPLE_BITS-1:0]      req_depth_sample,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dmd_pkg::SAMPLE_BITS-1:0]      rsp_filtered_depth,
   output logic [dmd_pkg::COORD_BITS-1:0]       rsp_out_column,
   output logic [dmd_pkg::COORD_BITS-1:0]       rsp_out_row,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_write_enable,
   input  logic [dmd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dmd_pkg::SIZE_BITS-1:0]        csr_write_data
);

   import dmd_pkg::*;

   `include "depth_median3x3_decimate2_assert.svh"

   // configuration
   size_type width_ff, height_ff;
   size_type width_even, height_even;
   wlim_type w_lim;
   hlim_type h_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_BITS'(512);
         height_ff <= SIZE_BITS'(424);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
         endcase
      end
   end

   assign width_even  = width_ff & ~SIZE_BITS'(1);
   assign height_even = height_ff & ~SIZE_BITS'(1);

   // saturate the sizes to 2..max
   always_comb begin
      if (width_even < SIZE_BITS'(2)) begin
         w_lim = wlim_type'(2);
      end else if (32'(width_even) > MAX_WIDTH) begin
         w_lim = wlim_type'(MAX_WIDTH);
      end else begin
         w_lim = wlim_type'(width_even);
      end
      if (height_even < SIZE_BITS'(2)) begin
         h_lim = hlim_type'(2);
      end else if (32'(height_even) > MAX_HEIGHT) begin
         h_lim = hlim_type'(MAX_HEIGHT);
      end else begin
         h_lim = hlim_type'(height_even);
      end
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic rsp_free, s1_adv, s2_adv, req_accept;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s2_adv     = s2_valid_ff && rsp_free;
   // the window changes with every pixel, so hold while a result still needs it
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_free);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   // position counters
   col_type  col_ff, col_in, col_cur;
   row_type  row_ff, row_in, row_cur;
   wlim_type col_inc;
   hlim_type row_inc;
   logic     emit_cur, pass_cur, last_cur;

   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      if ({1'b0, col_cur} >= w_lim) begin
         col_cur = '0;
      end
      if ({1'b0, row_cur} >= h_lim) begin
         row_cur = '0;
      end
      col_inc = {1'b0, col_cur} + wlim_type'(1);
      row_inc = {1'b0, row_cur} + hlim_type'(1);
      if (col_inc >= w_lim) begin
         col_in = '0;
         row_in = (row_inc >= h_lim) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
         col_in = col_inc[COL_BITS-1:0];
         row_in = row_cur;
      end
      emit_cur = col_cur[0] && row_cur[0];
      pass_cur = (col_cur == col_type'(1)) || (row_cur == row_type'(1));
      last_cur = ({1'b0, col_cur} == w_lim - wlim_type'(1))
              && ({1'b0, row_cur} == h_lim - hlim_type'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store read lands here
   pixel_type s1_pix_ff;
   col_type   s1_col_ff;
   logic      s1_emit_ff, s1_pass_ff, s1_last_ff;
   logic [COORD_BITS-1:0] s1_ocol_ff, s1_orow_ff;
   logic      hit_ff, hit_in;
   pixel_type fwd_upper_ff, fwd_middle_ff;
   pixel_type upper_rd, middle_rd, upper_eff, middle_eff;

   assign hit_in     = s1_adv && (s1_col_ff == col_cur);
   assign upper_eff  = hit_ff ? fwd_upper_ff : upper_rd;
   assign middle_eff = hit_ff ? fwd_middle_ff : middle_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= req_depth_sample[PIXEL_BITS-1:0];
         s1_col_ff     <= col_cur;
         s1_emit_ff    <= emit_cur;
         s1_pass_ff    <= pass_cur;
         s1_last_ff    <= last_cur;
         s1_ocol_ff    <= COORD_BITS'(col_cur >> 1);
         s1_orow_ff    <= COORD_BITS'(row_cur >> 1);
         // forward the word being written this edge to a reader of the same column
         hit_ff        <= hit_in;
         fwd_upper_ff  <= middle_eff;
         fwd_middle_ff <= s1_pix_ff;
      end
   end

   dmd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (middle_eff),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (upper_rd)
   );

   dmd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (middle_rd)
   );

   // window: three sorted columns, index 2 newest
   column_type col_new;
   column_type win_ff [3];
   pixel_type  win_md_ff [3];
   pixel_type  raw_mid_ff;

   assign col_new = sort3(upper_eff, middle_eff, s1_pix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i]    <= '0;
            win_md_ff[i] <= '0;
         end
         raw_mid_ff <= '0;
      end else if (s1_adv) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2]    <= col_new;
         win_md_ff[0] <= win_md_ff[1];
         win_md_ff[1] <= win_md_ff[2];
         win_md_ff[2] <= col_new.md;
         raw_mid_ff   <= middle_eff;
      end
   end

   // stage 2: median of the window
   logic      s2_pass_ff, s2_last_ff;
   pixel_type s2_thru_ff;
   logic [COORD_BITS-1:0] s2_ocol_ff, s2_orow_ff;
   pixel_type lo_max, md_med, hi_min, median;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_emit_ff;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_pass_ff <= s1_pass_ff;
         s2_last_ff <= s1_last_ff;
         s2_ocol_ff <= s1_ocol_ff;
         s2_orow_ff <= s1_orow_ff;
         // centre of the shifted window
         s2_thru_ff <= raw_mid_ff;
      end
   end

   assign lo_max = max3(win_ff[0].lo, win_ff[1].lo, win_ff[2].lo);
   assign md_med = med3(win_md_ff[0], win_md_ff[1], win_md_ff[2]);
   assign hi_min = min3(win_ff[0].hi, win_ff[1].hi, win_ff[2].hi);
   assign median = med3(lo_max, md_med, hi_min);

   // output register
   pixel_type rsp_depth_ff;
   logic [COORD_BITS-1:0] rsp_col_ff, rsp_row_ff;
   logic rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_depth_ff <= s2_pass_ff ? s2_thru_ff : median;
         rsp_col_ff   <= s2_ocol_ff;
         rsp_row_ff   <= s2_orow_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_depth = SAMPLE_BITS'(rsp_depth_ff);
   assign rsp_out_column     = rsp_col_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_frame_last     = rsp_last_ff;

   `ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_accept, s1_valid_ff)
   `ASSERT_NEXT(a_emit_reaches_s2, clock, reset, s1_adv && s1_emit_ff, s2_valid_ff)
   `ASSERT_NEXT(a_window_holds, clock, reset, s2_valid_ff && !rsp_free, $stable(win_md_ff[1]))
   `ASSERT_IMPLIES(a_bypass_needs_s1, clock, reset, hit_ff && s1_adv, s1_valid_ff)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import dmd_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_PIXEL = 300;
   localparam int RANDOM_PIXELS = 830;

   typedef struct packed {
      pixel_type             depth;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic                  last;
   } reduced_word_type;

   typedef struct {
      pixel_type        pix;
      bit               start;
      bit               fixed;
      reduced_word_type want;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_depth_sample = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_filtered_depth;
   logic [COORD_BITS-1:0]     rsp_out_column;
   logic [COORD_BITS-1:0]     rsp_out_row;
   logic                      rsp_frame_last;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [SIZE_BITS-1:0]      csr_write_data = '0;

   // filter state as the stream builds it
   pixel_type        upper_row  [MAX_WIDTH] = '{default: '0};
   pixel_type        middle_row [MAX_WIDTH] = '{default: '0};
   pixel_type        win [3][3] = '{default: '{default: '0}};
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   size_type         width_reg = 11'd512;
   size_type         height_reg = 11'd424;
   reduced_word_type reduced_expected [$];

   int unsigned   fault_count = 0;
   int unsigned   pixels_sent = 0;
   int unsigned   quiet_cycles = 0;
   bit            idle_on = 1'b0;
   bit            hold_off_request = 1'b0;

   always #6 clock = ~clock;

   depth_median3x3_decimate2 dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_depth_sample   (req_depth_sample),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_depth (rsp_filtered_depth),
      .rsp_out_column     (rsp_out_column),
      .rsp_out_row        (rsp_out_row),
      .rsp_frame_last     (rsp_frame_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   function automatic int unsigned eff_size(input size_type v, input int unsigned top);
      int unsigned s;
      s = 32'(v & 11'h7FE);
      if (s < 2) s = 2;
      if (s > top) s = top;
      return s;
   endfunction

   function automatic pixel_type window_median();
      pixel_type v [9];
      pixel_type t;
      int        i;
      int        j;
      for (i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
      for (i = 0; i < 8; i++) begin
         for (j = 0; j < 8 - i; j++) begin
            if (v[j] > v[j + 1]) begin
               t = v[j];
               v[j] = v[j + 1];
               v[j + 1] = t;
            end
         end
      end
      return v[4];
   endfunction

   function automatic void reduce_pixel(input pixel_type pix, input bit start,
                                        output bit emitted, output reduced_word_type word);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int          k;
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, MAX_HEIGHT);
      emitted = 1'b0;
      word = '0;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      for (k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = upper_row[c];
      win[1][2] = middle_row[c];
      win[2][2] = pix;
      upper_row[c] = middle_row[c];
      middle_row[c] = pix;
      // a reduced pixel completes on odd column and odd row
      if ((c % 2 == 1) && (r % 2 == 1)) begin
         emitted = 1'b1;
         word.depth = (c == 1 || r == 1) ? win[1][1] : window_median();
         word.column = COORD_BITS'(c / 2);
         word.row = COORD_BITS'(r / 2);
         word.last = (c == w - 1) && (r == h - 1);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic pixel_type pick_pixel(input int mode);
      if (mode == 0) return pixel_type'($urandom);
      // narrow range: plenty of ties in the window
      if (mode == 1) return pixel_type'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input pixel_type pix, input bit start, input bit fixed,
                             input reduced_word_type typed);
      bit               hit;
      reduced_word_type got;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_depth_sample <= pix;
      req_frame_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reduce_pixel(pix, start, hit, got);
      if (fixed) reduced_expected.push_back(typed);
      else if (hit) reduced_expected.push_back(got);
      pixels_sent++;
      if (pixels_sent == HOLD_AT_PIXEL) hold_off_request = 1'b1;
   endtask

   // drop valid, wait for every reduced word, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (reduced_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_frame_size(input size_type w, input size_type h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      width_reg = w;
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      height_reg = h;
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input size_type w, input size_type h, input int unsigned n,
                            input bit lead, input bit noisy, input bit idle);
      int          mode;
      bit          start;
      int unsigned i;
      settle();
      set_frame_size(w, h);
      idle_on = idle;
      mode = int'($urandom_range(0, 2));
      for (i = 0; i < n; i++) begin
         start = (i == 0) ? lead : (noisy && $urandom_range(0, 99) == 0);
         send_pixel(pick_pixel(mode), start, 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_type directed_rows [24];
      int unsigned  target;
      int unsigned  frame;
      int unsigned  count;
      size_type     w;
      size_type     h;
      int           sel;
      bit           lead;
      // 4x4 frame, then a wrap into the next frame and a restart mid-row
      directed_rows = '{
         '{16'h0000, 1'b1, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h5555, 1'b0, 1'b0, '0},
         '{16'hAAAA, 1'b0, 1'b0, '0},
         '{16'h1234, 1'b0, 1'b0, '0},
         '{16'h0001, 1'b0, 1'b1, '{16'h0000, 9'd0, 9'd0, 1'b0}},
         '{16'h8000, 1'b0, 1'b0, '0},
         '{16'h7FFF, 1'b0, 1'b1, '{16'h5555, 9'd1, 9'd0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h0000, 1'b0, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h0000, 1'b0, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 9'd0, 9'd1, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'hFFFF, 1'b0, 1'b0, '0},
         '{16'h0F0F, 1'b0, 1'b0, '0},
         '{16'hC3C3, 1'b1, 1'b0, '0},
         '{16'h3C3C, 1'b0, 1'b0, '0},
         '{16'h00FF, 1'b0, 1'b0, '0},
         '{16'hFF00, 1'b0, 1'b0, '0},
         '{16'h8001, 1'b0, 1'b0, '0},
         '{16'h7FFE, 1'b0, 1'b1, '{16'hC3C3, 9'd0, 9'd0, 1'b0}}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // odd width: low bit dropped
      set_frame_size(11'd5, 11'd4);
      idle_on = 1'b1;
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].pix, directed_rows[i].start, directed_rows[i].fixed,
                    directed_rows[i].want);

      // stop at column 12 of row 6, then shrink both sizes: position wraps
      run_phase(11'd16, 11'd9, 108, 1'b1, 1'b0, 1'b1);
      run_phase(11'd8, 11'd4, 40, 1'b0, 1'b0, 1'b1);
      // size extremes: zero and full-scale codes saturate, odd codes drop the low bit
      run_phase(11'h000, 11'h7FF, 40, 1'b1, 1'b0, 1'b1);
      run_phase(11'd3, 11'd1, 12, 1'b1, 1'b0, 1'b1);

      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         sel = int'($urandom_range(0, 9));
         if (sel == 0) begin
            w = size_type'($urandom_range(0, 3));
            h = size_type'($urandom_range(0, 12));
         end else if (sel == 1) begin
            w = size_type'($urandom_range(60, 160));
            h = size_type'($urandom_range(0, 5));
         end else begin
            w = size_type'($urandom_range(4, 26));
            h = size_type'($urandom_range(4, 12));
         end
         frame = eff_size(w, MAX_WIDTH) * eff_size(h, MAX_HEIGHT);
         // a wider row must start a new frame so no unwritten column is read
         lead = (eff_size(w, MAX_WIDTH) > eff_size(width_reg, MAX_WIDTH)) ||
                ($urandom_range(0, 1) == 1);
         count = $urandom_range(frame, frame + frame / 2);
         // stop at the budget, mid-frame if need be
         if (count > target - pixels_sent) count = target - pixels_sent;
         run_phase(w, h, count, lead, 1'b1, $urandom_range(0, 3) != 0);
      end

      run_phase(11'd8, 11'd6, 96, 1'b1, 1'b0, 1'b0);
      settle();
      repeat (20) @(posedge clock);
      if (fault_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      reduced_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reduced_expected.size() == 0) begin
            $error("unexpected word: depth %h column %0d row %0d last %0b",
                   rsp_filtered_depth, rsp_out_column, rsp_out_row, rsp_frame_last);
            fault_count++;
         end else begin
            want = reduced_expected.pop_front();
            if (rsp_filtered_depth !== want.depth) begin
               $error("filtered_depth: expected %h, got %h", want.depth, rsp_filtered_depth);
               fault_count++;
            end
            if (rsp_out_column !== want.column) begin
               $error("out_column: expected %0d, got %0d", want.column, rsp_out_column);
               fault_count++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               fault_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
               fault_count++;
            end
         end
      end
   end

   // hang check: no word moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
